// File: rtl/ofb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofb_pkg
// Shared constants, codes and types of the OLED page frame buffer.
// ----------------------------------------------------------------------------
package ofb_pkg;

  // Panel geometry
  localparam int COLUMNS    = 128;
  localparam int PAGES      = 8;
  localparam int DEPTH      = COLUMNS * PAGES;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int HEADER_LEN = 3;
  localparam int POS_W      = $clog2(COLUMNS + HEADER_LEN);
  localparam int LAST_POS   = HEADER_LEN + COLUMNS - 1;
  localparam int ROWS       = 8 * PAGES;

  // Panel command bytes sent ahead of each page
  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [7:0] COL_LOW_CMD   = 8'h00;
  localparam logic [7:0] COL_HIGH_CMD  = 8'h10;

  // Stream header positions
  localparam logic [POS_W-1:0] POS_PAGE_CMD = POS_W'(0);
  localparam logic [POS_W-1:0] POS_COL_LOW  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_COL_HIGH = POS_W'(2);

  // Result kinds
  localparam logic KIND_GET    = 1'b0;
  localparam logic KIND_STREAM = 1'b1;

  typedef enum logic [2:0] {
    CMD_SET   = 3'd0,
    CMD_GET   = 3'd1,
    CMD_FILL  = 3'd2,
    CMD_START = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_WRITE,
    ST_EMIT
  } state_t;

  // Store access from the controller
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Controller status seen by the top level checks
  typedef struct packed {
    logic sweeping;
    logic stream_active;
  } status_t;

  // Byte address of a column within a page
  function automatic logic [ADDR_W-1:0] store_addr(input logic [7:0] col,
                                                   input logic [7:0] page);
    store_addr = ADDR_W'(32'(col) * 32'(PAGES) + 32'(page));
  endfunction

endpackage

// File: rtl/ofb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofb_in_if / ofb_out_if
// Valid/ready channels for commands into and results out of the frame buffer.
// ----------------------------------------------------------------------------
interface ofb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] column;
  logic [7:0] row;
  logic [2:0] page_sel;
  logic       pixel_value;
  logic [7:0] fill_byte;

  modport source (
    output valid, cmd, column, row, page_sel, pixel_value, fill_byte,
    input  ready
  );
  modport sink (
    input  valid, cmd, column, row, page_sel, pixel_value, fill_byte,
    output ready
  );
endinterface

interface ofb_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_byte;
  logic       is_data;
  logic       stream_last;

  modport source (
    output valid, kind, out_byte, is_data, stream_last,
    input  ready
  );
  modport sink (
    input  valid, kind, out_byte, is_data, stream_last,
    output ready
  );
endinterface

// File: rtl/ofb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofb_store
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ofb_store
  import ofb_pkg::*;
(
  input  logic     clk,
  input  mem_req_t mem_req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rd_data_r <= mem[mem_req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/ofb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofb_ctrl
// Command sequencer: pixel read-modify-write, byte reads, store sweeps,
// refresh stream counters and the result register.
// ----------------------------------------------------------------------------
module ofb_ctrl
  import ofb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ofb_in_if.sink     in_ch,
  ofb_out_if.source  out_ch,
  output mem_req_t   mem_req,
  input  logic [7:0] rd_data,
  output status_t    status
);

  state_t              state_r,       state_nxt;
  logic [ADDR_W-1:0]   sweep_addr_r,  sweep_addr_nxt;
  logic [7:0]          sweep_val_r,   sweep_val_nxt;
  logic                active_r,      active_nxt;
  logic [PAGE_W-1:0]   page_r,        page_nxt;
  logic [POS_W-1:0]    pos_r,         pos_nxt;
  logic                out_valid_r,   out_valid_nxt;

  // Pending pixel write
  logic [ADDR_W-1:0]   wr_addr_r,     wr_addr_nxt;
  logic [2:0]          bit_sel_r,     bit_sel_nxt;
  logic                pix_r,         pix_nxt;

  // Pending result
  logic                pend_kind_r,   pend_kind_nxt;
  logic [7:0]          pend_byte_r,   pend_byte_nxt;
  logic                pend_ram_r,    pend_ram_nxt;
  logic                pend_data_r,   pend_data_nxt;
  logic                pend_last_r,   pend_last_nxt;

  // Result register
  logic                kind_r,        kind_nxt;
  logic [7:0]          out_byte_r,    out_byte_nxt;
  logic                is_data_r,     is_data_nxt;
  logic                last_r,        last_nxt;

  logic                out_free;
  logic [7:0]          mask;

  assign out_free = !out_valid_r || out_ch.ready;
  assign mask     = 8'b1 << bit_sel_r;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.is_data     = is_data_r;
  assign out_ch.stream_last = last_r;

  assign status.sweeping      = (state_r == ST_SWEEP);
  assign status.stream_active = active_r;

  // Next state, store access and result loading
  always_comb begin
    state_nxt      = state_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_val_nxt  = sweep_val_r;
    active_nxt     = active_r;
    page_nxt       = page_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = out_valid_r;
    wr_addr_nxt    = wr_addr_r;
    bit_sel_nxt    = bit_sel_r;
    pix_nxt        = pix_r;
    pend_kind_nxt  = pend_kind_r;
    pend_byte_nxt  = pend_byte_r;
    pend_ram_nxt   = pend_ram_r;
    pend_data_nxt  = pend_data_r;
    pend_last_nxt  = pend_last_r;
    kind_nxt       = kind_r;
    out_byte_nxt   = out_byte_r;
    is_data_nxt    = is_data_r;
    last_nxt       = last_r;
    mem_req        = '0;

    // Drop the result beat once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_SWEEP: begin
        // Write one entry a cycle until the whole store holds the value
        mem_req.we    = 1'b1;
        mem_req.waddr = sweep_addr_r;
        mem_req.wdata = sweep_val_r;
        if (sweep_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          sweep_addr_nxt = sweep_addr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_ch.valid) begin
          case (cmd_t'(in_ch.cmd))
            CMD_SET: begin
              if (32'(in_ch.column) < COLUMNS && 32'(in_ch.row) < ROWS) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = store_addr(in_ch.column, 8'(in_ch.row >> 3));
                wr_addr_nxt   = mem_req.raddr;
                bit_sel_nxt   = in_ch.row[2:0];
                pix_nxt       = in_ch.pixel_value;
                state_nxt     = ST_WRITE;
              end
            end
            CMD_GET: begin
              pend_kind_nxt = KIND_GET;
              pend_data_nxt = 1'b0;
              pend_last_nxt = 1'b0;
              pend_byte_nxt = 8'h00;
              pend_ram_nxt  = 1'b0;
              if (32'(in_ch.column) < COLUMNS && 32'(in_ch.page_sel) < PAGES) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = store_addr(in_ch.column, 8'(in_ch.page_sel));
                pend_ram_nxt  = 1'b1;
              end
              state_nxt = ST_EMIT;
            end
            CMD_FILL: begin
              sweep_addr_nxt = '0;
              sweep_val_nxt  = in_ch.fill_byte;
              state_nxt      = ST_SWEEP;
            end
            CMD_START: begin
              active_nxt = 1'b1;
              page_nxt   = '0;
              pos_nxt    = '0;
            end
            CMD_TICK: begin
              if (active_r) begin
                pend_kind_nxt = KIND_STREAM;
                pend_ram_nxt  = 1'b0;
                pend_data_nxt = 1'b0;
                pend_last_nxt = 1'b0;
                case (pos_r)
                  POS_PAGE_CMD: pend_byte_nxt = PAGE_CMD_BASE + 8'(page_r);
                  POS_COL_LOW:  pend_byte_nxt = COL_LOW_CMD;
                  POS_COL_HIGH: pend_byte_nxt = COL_HIGH_CMD;
                  default: begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = store_addr(8'(pos_r - POS_W'(HEADER_LEN)),
                                               8'(page_r));
                    pend_ram_nxt  = 1'b1;
                    pend_data_nxt = 1'b1;
                    pend_byte_nxt = 8'h00;
                  end
                endcase
                // Advance the stream position
                if (pos_r == POS_W'(LAST_POS)) begin
                  pos_nxt = '0;
                  if (page_r == PAGE_W'(PAGES - 1)) begin
                    pend_last_nxt = 1'b1;
                    active_nxt    = 1'b0;
                    page_nxt      = '0;
                  end else begin
                    page_nxt = page_r + 1'b1;
                  end
                end else begin
                  pos_nxt = pos_r + 1'b1;
                end
                state_nxt = ST_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_WRITE: begin
        // Merge the pixel into the byte read last cycle; the input is held
        // off here, so no later read can overlap this write
        mem_req.we    = 1'b1;
        mem_req.waddr = wr_addr_r;
        mem_req.wdata = pix_r ? (rd_data | mask) : (rd_data & ~mask);
        state_nxt     = ST_IDLE;
      end

      ST_EMIT: begin
        // Hold until the result register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = pend_kind_r;
          out_byte_nxt  = pend_ram_r ? rd_data : pend_byte_r;
          is_data_nxt   = pend_data_r;
          last_nxt      = pend_last_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      sweep_addr_r <= '0;
      sweep_val_r  <= 8'h00;
      active_r     <= 1'b0;
      page_r       <= '0;
      pos_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_val_r  <= sweep_val_nxt;
      active_r     <= active_nxt;
      page_r       <= page_nxt;
      pos_r        <= pos_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wr_addr_r   <= wr_addr_nxt;
    bit_sel_r   <= bit_sel_nxt;
    pix_r       <= pix_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_ram_r  <= pend_ram_nxt;
    pend_data_r <= pend_data_nxt;
    pend_last_r <= pend_last_nxt;
    kind_r      <= kind_nxt;
    out_byte_r  <= out_byte_nxt;
    is_data_r   <= is_data_nxt;
    last_r      <= last_nxt;
  end

endmodule

// File: rtl/oled_page_frame_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oled_page_frame_buffer
// Page-mode frame store for a monochrome OLED panel with refresh streaming.
// ----------------------------------------------------------------------------
// The store (COLUMNS x PAGES bytes, one single-port-write RAM with a
// registered read) is cleared by a sweep after reset, during which no
// command is taken. Commands are handled one at a time: a set point reads,
// then writes back the merged byte; a get or a tick reads, then loads the
// result once the result register is free; fill walks the RAM one entry a
// cycle. The single RAM port pair and the read-modify-write of each pixel
// set the pace. A new command is taken while a finished result still waits
// to be read.
// ----------------------------------------------------------------------------
module oled_page_frame_buffer
  import ofb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ofb_in_if.sink    in_ch,
  ofb_out_if.source out_ch
);

  mem_req_t   mem_req;
  logic [7:0] rd_data;
  status_t    status;

  ofb_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  ofb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mem_req (mem_req),
    .rd_data (rd_data),
    .status  (status)
  );

  // No command taken while the store is being swept
  a_no_accept_in_sweep : assert property (@(posedge clk) disable iff (!rst_n)
    status.sweeping |-> !in_ch.ready)
    else $error("command accepted during store sweep");

  // The final stream beat is a refresh data byte
  a_last_is_stream_data : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.stream_last) |-> (out_ch.kind && out_ch.is_data))
    else $error("stream_last on a beat that is not stream data");

  // A get reply carries no panel flags
  a_get_reply_flags : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.kind) |-> (!out_ch.is_data && !out_ch.stream_last))
    else $error("get reply with stream flags set");

  // A stream is armed only by an accepted start command
  a_stream_arm : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(status.stream_active) |->
      $past(in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_START)))
    else $error("refresh stream armed without a start command");

endmodule
